// ===== sv/mtfp_pkg.sv =====
// Shared types and constants for the tape file parser.
`timescale 1ns / 1ps

package mtfp_pkg;

  // Depth of the event and result queues (power of two).
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int NAME_LEN = 6;

  localparam logic [7:0] TYPE_BYTE_BINARY = 8'hd0;
  localparam logic [7:0] TYPE_BYTE_BASIC  = 8'hd3;
  localparam logic [7:0] TYPE_BYTE_ASCII  = 8'hea;
  localparam logic [7:0] NAME_ERR_BYTE    = 8'hff;

  localparam logic [15:0] BASIC_BASE_RESET  = 16'h8001;
  localparam logic [8:0]  SEGMENT_LEN_RESET = 9'd256;
  localparam logic [7:0]  EOF_CHAR_RESET    = 8'h1a;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_BASIC_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EOF_CHAR    = 2'd2;

  typedef enum logic [1:0] {
    EV_BYTE     = 2'd0,
    EV_ERROR    = 2'd1,
    EV_HEADER   = 2'd2,
    EV_NOHEADER = 2'd3
  } event_t;

  typedef enum logic [2:0] {
    K_NAME     = 3'd0,
    K_DATA     = 3'd1,
    K_DATA_END = 3'd2,
    K_COMPLETE = 3'd3,
    K_ABANDON  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    FT_BINARY = 2'd0,
    FT_BASIC  = 2'd1,
    FT_ASCII  = 2'd2
  } file_type_t;

  typedef enum logic [3:0] {
    PH_AWAIT      = 4'd0,
    PH_TYPE       = 4'd1,
    PH_NAME       = 4'd2,
    PH_ASCII_SEEK = 4'd3,
    PH_ASCII_SEG  = 4'd4,
    PH_BODY_SEEK  = 4'd5,
    PH_BIN_ADDR   = 4'd6,
    PH_BIN_DATA   = 4'd7,
    PH_BAS_LINK   = 4'd8,
    PH_BAS_LINE   = 4'd9
  } phase_t;

  typedef struct packed {
    event_t     ev;
    logic [7:0] data;
  } tape_event_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  value;
    file_type_t  file_type;
    logic [15:0] start_address;
    logic [15:0] exec_address;
  } result_t;

  typedef struct packed {
    logic [15:0] basic_base;
    logic [8:0]  segment_len;
    logic [7:0]  eof_char;
  } cfg_t;

endpackage

// ===== sv/msx_tape_file_parser.sv =====
// Top level of the tape file parser: config registers, front end, parser, result queue.
//
// Input channel: drive op and byte_value with push high; the event transfers
// at a clock edge where push is high and full is low. Events are queued in a
// two-entry front queue and classified there.
// Result channel: while empty is low the oldest result sits on kind, value,
// file_type, start_address and exec_address; it transfers at an edge where
// pop is high. Events that produce no result simply vanish.
// An event passes the registered front queue, the combinational parser and
// the registered result queue before its result is on the result ports.
// Throughput: one event per cycle while the result queue has room, set by the
// parser state machine that retires one queued event each clock it is not stalled.
// The parser stalls only while the two-entry result queue is full; the front
// queue then fills and raises full, so a stalled consumer pushes back without
// loss. Configuration: cfg_wr_en with cfg_index and cfg_data writes a
// register; indexes beyond the last register are ignored.
// Reset (rst, synchronous): clears both queues, returns the parser to waiting
// for a type header and loads the register defaults.
`timescale 1ns / 1ps

module msx_tape_file_parser #(
  parameter int TYPE_REPEAT = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [1:0]                         op,
  input  logic [7:0]                         byte_value,
  output logic                               empty,
  input  logic                               pop,
  output logic [2:0]                         kind,
  output logic [7:0]                         value,
  output logic [1:0]                         file_type,
  output logic [15:0]                        start_address,
  output logic [15:0]                        exec_address,
  input  logic                               cfg_wr_en,
  input  logic [mtfp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mtfp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mtfp_pkg::*;

  cfg_t        cfg;
  logic        ev_valid;
  tape_event_t ev;
  logic        ev_take;
  logic        res_full;
  logic        res_push;
  result_t     res_in;
  result_t     res_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.basic_base  <= BASIC_BASE_RESET;
      cfg.segment_len <= SEGMENT_LEN_RESET;
      cfg.eof_char    <= EOF_CHAR_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BASIC_BASE:  cfg.basic_base  <= cfg_data;
        REG_SEGMENT_LEN: cfg.segment_len <= cfg_data[8:0];
        REG_EOF_CHAR:    cfg.eof_char    <= cfg_data[7:0];
        default:         cfg             <= cfg;
      endcase
    end
  end

  mtfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .op         (op),
    .byte_value (byte_value),
    .ev_valid   (ev_valid),
    .ev         (ev),
    .ev_take    (ev_take)
  );

  mtfp_back #(
    .TYPE_REPEAT (TYPE_REPEAT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .ev_valid (ev_valid),
    .ev       (ev),
    .ev_take  (ev_take),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  mtfp_out u_out (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_in   (res_in),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .res_out  (res_out)
  );

  assign kind          = res_out.kind;
  assign value         = res_out.value;
  assign file_type     = res_out.file_type;
  assign start_address = res_out.start_address;
  assign exec_address  = res_out.exec_address;

endmodule

// ===== sv/mtfp_front.sv =====
// Front end: classifies tape events and queues them for the parser.
`timescale 1ns / 1ps

module mtfp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           op,
  input  logic [7:0]           byte_value,
  output logic                 ev_valid,
  output mtfp_pkg::tape_event_t ev,
  input  logic                 ev_take
);
  import mtfp_pkg::*;

  tape_event_t            slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  tape_event_t            in_ev;
  logic                   wr;
  logic                   rd;

  always_comb begin
    in_ev.data = byte_value;
    in_ev.ev   = event_t'(op);
  end

  assign full     = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign ev_valid = (count != '0);
  assign ev       = slots[rd_ptr];
  assign wr       = push && !full;
  assign rd       = ev_take && ev_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= in_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/mtfp_back.sv =====
// Back end: file format state machine, one queued event per cycle while the result queue has room.
`timescale 1ns / 1ps

module mtfp_back #(
  parameter int TYPE_REPEAT = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mtfp_pkg::cfg_t        cfg,
  input  logic                  ev_valid,
  input  mtfp_pkg::tape_event_t ev,
  output logic                  ev_take,
  input  logic                  res_full,
  output logic                  res_push,
  output mtfp_pkg::result_t     res
);
  import mtfp_pkg::*;

  phase_t      phase, phase_next;
  logic [8:0]  byte_count, byte_count_next;
  logic [7:0]  first_type_byte, first_type_byte_next;
  logic        all_same, all_same_next;
  file_type_t  current_type, current_type_next;
  logic [15:0] remaining_length, remaining_length_next;
  logic [15:0] line_address, line_address_next;
  logic [7:0]  link_low, link_low_next;
  logic [15:0] start_reg, start_reg_next;
  logic [15:0] end_reg, end_reg_next;
  logic [15:0] entry_reg, entry_reg_next;
  logic        eof_seen, eof_seen_next;

  logic        go;
  logic        res_valid;
  kind_t       res_kind;
  logic [7:0]  res_value;
  logic        do_abandon;
  logic [8:0]  bc_inc;
  logic [15:0] link_word;
  logic [16:0] line_plus2;
  logic [15:0] line_gap;
  logic        is_err;
  logic [7:0]  b;

  assign go         = ev_valid && !res_full;
  assign ev_take    = go;
  assign res_push   = go && res_valid;
  assign bc_inc     = byte_count + 9'd1;
  assign b          = ev.data;
  assign is_err     = (ev.ev == EV_ERROR);
  assign link_word  = {b, link_low};
  assign line_plus2 = {1'b0, line_address} + 17'd2;
  assign line_gap   = link_word - line_address - 16'd2;

  always_comb begin
    phase_next            = phase;
    byte_count_next       = byte_count;
    first_type_byte_next  = first_type_byte;
    all_same_next         = all_same;
    current_type_next     = current_type;
    remaining_length_next = remaining_length;
    line_address_next     = line_address;
    link_low_next         = link_low;
    start_reg_next        = start_reg;
    end_reg_next          = end_reg;
    entry_reg_next        = entry_reg;
    eof_seen_next         = eof_seen;
    res_valid             = 1'b0;
    res_kind              = K_DATA;
    res_value             = '0;
    do_abandon            = 1'b0;

    case (ev.ev)
      EV_NOHEADER: begin
        if (phase == PH_TYPE) begin
          phase_next = PH_AWAIT;
        end else if (phase != PH_AWAIT) begin
          do_abandon = 1'b1;
          phase_next = PH_AWAIT;
        end
      end

      EV_HEADER: begin
        case (phase)
          PH_AWAIT, PH_TYPE: begin
            phase_next           = PH_TYPE;
            byte_count_next      = '0;
            all_same_next        = 1'b1;
            first_type_byte_next = '0;
          end
          PH_ASCII_SEEK: begin
            phase_next      = PH_ASCII_SEG;
            byte_count_next = '0;
            eof_seen_next   = 1'b0;
          end
          PH_BODY_SEEK: begin
            byte_count_next = '0;
            if (current_type == FT_BINARY) begin
              phase_next = PH_BIN_ADDR;
            end else if (cfg.basic_base == '0) begin
              do_abandon = 1'b1;
              phase_next = PH_AWAIT;
            end else begin
              line_address_next = cfg.basic_base;
              phase_next        = PH_BAS_LINK;
            end
          end
          default: begin
            // drop the open file and start a fresh type header
            do_abandon           = 1'b1;
            phase_next           = PH_TYPE;
            byte_count_next      = '0;
            all_same_next        = 1'b1;
            first_type_byte_next = '0;
          end
        endcase
      end

      default: begin
        case (phase)
          PH_TYPE: begin
            if (is_err) begin
              phase_next = PH_AWAIT;
            end else begin
              if (byte_count == '0) begin
                first_type_byte_next = b;
              end else if (b != first_type_byte) begin
                all_same_next = 1'b0;
              end
              byte_count_next = bc_inc;
              if (bc_inc >= 9'(TYPE_REPEAT)) begin
                phase_next = PH_AWAIT;
                if (all_same_next && (first_type_byte_next == TYPE_BYTE_BINARY ||
                    first_type_byte_next == TYPE_BYTE_BASIC ||
                    first_type_byte_next == TYPE_BYTE_ASCII)) begin
                  case (first_type_byte_next)
                    TYPE_BYTE_BINARY: current_type_next = FT_BINARY;
                    TYPE_BYTE_BASIC:  current_type_next = FT_BASIC;
                    default:          current_type_next = FT_ASCII;
                  endcase
                  start_reg_next  = '0;
                  end_reg_next    = '0;
                  entry_reg_next  = '0;
                  byte_count_next = '0;
                  phase_next      = PH_NAME;
                end
              end
            end
          end

          PH_NAME: begin
            byte_count_next = bc_inc;
            if (bc_inc >= 9'(NAME_LEN)) begin
              phase_next = (current_type == FT_ASCII) ? PH_ASCII_SEEK : PH_BODY_SEEK;
            end
            res_valid = 1'b1;
            res_kind  = K_NAME;
            res_value = is_err ? NAME_ERR_BYTE : b;
          end

          PH_ASCII_SEG: begin
            if (is_err) begin
              do_abandon = 1'b1;
              phase_next = PH_AWAIT;
            end else begin
              if (b == cfg.eof_char) eof_seen_next = 1'b1;
              byte_count_next = bc_inc;
              res_valid       = 1'b1;
              res_kind        = K_DATA;
              res_value       = b;
              if (bc_inc == cfg.segment_len) begin
                if (eof_seen_next) begin
                  phase_next = PH_AWAIT;
                  res_kind   = K_DATA_END;
                end else begin
                  phase_next = PH_ASCII_SEEK;
                end
              end
            end
          end

          PH_BIN_ADDR: begin
            if (is_err) begin
              do_abandon = 1'b1;
              phase_next = PH_AWAIT;
            end else begin
              case (byte_count)
                9'd0:    start_reg_next = {8'h00, b};
                9'd1:    start_reg_next = {b, start_reg[7:0]};
                9'd2:    end_reg_next   = {8'h00, b};
                9'd3:    end_reg_next   = {b, end_reg[7:0]};
                9'd4:    entry_reg_next = {8'h00, b};
                default: entry_reg_next = {b, entry_reg[7:0]};
              endcase
              byte_count_next = bc_inc;
              if (bc_inc >= 9'(NAME_LEN)) begin
                remaining_length_next = end_reg_next - start_reg_next;
                if (end_reg_next < start_reg_next) begin
                  phase_next = PH_AWAIT;
                  res_valid  = 1'b1;
                  res_kind   = K_ABANDON;
                end else if (end_reg_next == start_reg_next) begin
                  phase_next = PH_AWAIT;
                  res_valid  = 1'b1;
                  res_kind   = K_COMPLETE;
                end else begin
                  phase_next = PH_BIN_DATA;
                end
              end
            end
          end

          PH_BIN_DATA: begin
            // read errors are counted but produce no data byte
            remaining_length_next = remaining_length - 16'd1;
            if (remaining_length_next == '0) begin
              phase_next = PH_AWAIT;
              res_valid  = 1'b1;
              res_kind   = is_err ? K_COMPLETE : K_DATA_END;
              res_value  = is_err ? 8'h00 : b;
            end else if (!is_err) begin
              res_valid = 1'b1;
              res_kind  = K_DATA;
              res_value = b;
            end
          end

          PH_BAS_LINK: begin
            if (is_err) begin
              do_abandon = 1'b1;
              phase_next = PH_AWAIT;
            end else if (byte_count == '0) begin
              link_low_next   = b;
              byte_count_next = 9'd1;
              res_valid       = 1'b1;
              res_kind        = K_DATA;
              res_value       = b;
            end else if (link_word == '0) begin
              phase_next = PH_AWAIT;
              res_valid  = 1'b1;
              res_kind   = K_DATA_END;
              res_value  = b;
            end else if ({1'b0, link_word} < line_plus2) begin
              do_abandon = 1'b1;
              phase_next = PH_AWAIT;
            end else begin
              remaining_length_next = line_gap;
              line_address_next     = link_word;
              byte_count_next       = '0;
              phase_next            = (line_gap != '0) ? PH_BAS_LINE : PH_BAS_LINK;
              res_valid             = 1'b1;
              res_kind              = K_DATA;
              res_value             = b;
            end
          end

          PH_BAS_LINE: begin
            if (is_err) begin
              do_abandon = 1'b1;
              phase_next = PH_AWAIT;
            end else begin
              remaining_length_next = remaining_length - 16'd1;
              if (remaining_length_next == '0) begin
                byte_count_next = '0;
                phase_next      = PH_BAS_LINK;
              end
              res_valid = 1'b1;
              res_kind  = K_DATA;
              res_value = b;
            end
          end

          default: begin
            // no block open: drop the byte
          end
        endcase
      end
    endcase

    if (do_abandon) begin
      if (phase == PH_BIN_ADDR) begin
        start_reg_next = '0;
        end_reg_next   = '0;
        entry_reg_next = '0;
      end
      res_valid = 1'b1;
      res_kind  = K_ABANDON;
      res_value = '0;
    end

    res.kind          = res_kind;
    res.value         = res_value;
    res.file_type     = current_type_next;
    res.start_address = start_reg_next;
    res.exec_address  = entry_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_AWAIT;
      byte_count       <= '0;
      first_type_byte  <= '0;
      all_same         <= 1'b1;
      current_type     <= FT_BINARY;
      remaining_length <= '0;
      line_address     <= '0;
      link_low         <= '0;
      start_reg        <= '0;
      end_reg          <= '0;
      entry_reg        <= '0;
      eof_seen         <= 1'b0;
    end else if (go) begin
      phase            <= phase_next;
      byte_count       <= byte_count_next;
      first_type_byte  <= first_type_byte_next;
      all_same         <= all_same_next;
      current_type     <= current_type_next;
      remaining_length <= remaining_length_next;
      line_address     <= line_address_next;
      link_low         <= link_low_next;
      start_reg        <= start_reg_next;
      end_reg          <= end_reg_next;
      entry_reg        <= entry_reg_next;
      eof_seen         <= eof_seen_next;
    end
  end

`ifndef SYNTHESIS
  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (ev_valid && !res_full))
    else $error("result transfer without a taken event or with a full queue");

  a_name_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_NAME) |-> (byte_count < 9'(NAME_LEN)))
    else $error("name byte count out of range");

  a_type_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TYPE) |-> (byte_count < 9'(TYPE_REPEAT)))
    else $error("type byte count out of range");

  a_bin_data_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BIN_DATA || phase == PH_BAS_LINE) |-> (remaining_length != '0))
    else $error("data phase with nothing left to read");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (!go) |=> $stable(phase))
    else $error("parser state moved without taking an event");
`endif

endmodule

// ===== sv/mtfp_out.sv =====
// Result queue between the parser and the consumer.
`timescale 1ns / 1ps

module mtfp_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_push,
  input  mtfp_pkg::result_t res_in,
  output logic              res_full,
  output logic              empty,
  input  logic              pop,
  output mtfp_pkg::result_t res_out
);
  import mtfp_pkg::*;

  result_t                slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   wr;
  logic                   rd;

  assign res_full = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign res_out  = slots[rd_ptr];
  assign wr       = res_push && !res_full;
  assign rd       = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
